[rtl/dale_pkg.sv]
// ----------------------------------------------------------------------------
// dale_pkg
// Shared types and codes for the address list with oldest-first eviction.
// ----------------------------------------------------------------------------
package dale_pkg;

	localparam int ADDR_W = 32;
	localparam int IDX_W  = 4;
	localparam int OP_W   = 2;

	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	// per-cell update controls
	typedef struct packed {
		logic shift;   // take the upper neighbor's entry (evict oldest)
		logic load;    // take the new address
	} cell_ctl_t;

endpackage

[rtl/dale_cell.sv]
// ----------------------------------------------------------------------------
// dale_cell
// One list slot: holds an address, shifts from its neighbor or loads a new
// address, and compares its entry with the request key.
// ----------------------------------------------------------------------------
module dale_cell (
	input  logic                              clk,
	input  dale_pkg::cell_ctl_t               ctl,
	input  logic                              live,
	input  logic [dale_pkg::ADDR_W-1:0]       nbr_data,
	input  logic [dale_pkg::ADDR_W-1:0]       new_data,
	input  logic [dale_pkg::ADDR_W-1:0]       key,
	output logic [dale_pkg::ADDR_W-1:0]       data,
	output logic                              match
);
	import dale_pkg::*;

	logic [ADDR_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= nbr_data;
		end else if (ctl.load) begin
			data_q <= new_data;
		end
	end

	// empty slots never match
	assign match = live && (data_q == key);
	assign data  = data_q;

endmodule

[rtl/dedup_address_list_evict_oldest_top.sv]
// ----------------------------------------------------------------------------
// dedup_address_list_evict_oldest_top
// Ordered set of up to DEPTH distinct IPv4 addresses, oldest at position 0.
// An add stores the address only when no stored entry equals it; on a full
// list the oldest entry drops out, the rest move down one slot and the new
// address lands at the top. A lookup reports presence, a read returns the
// entry at read_index with a valid flag, and every result carries the entry
// count after the request. Op code 3 changes nothing and returns zeros plus
// the current count. For each request all slots compare the key in parallel
// and the result is captured in a single output register, so a new request
// is taken every cycle while the output side keeps up. While a finished
// result is held by out_stall, in_stall is raised. Slots hold no reset
// value; only positions below the count are ever compared or read.
// ----------------------------------------------------------------------------
module dedup_address_list_evict_oldest_top #(
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request side
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [dale_pkg::OP_W-1:0]    op,
	input  logic [dale_pkg::ADDR_W-1:0]  ip_addr,
	input  logic [dale_pkg::IDX_W-1:0]   read_index,
	// result side
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic [$clog2(DEPTH + 1)-1:0] entry_count,
	output logic [dale_pkg::ADDR_W-1:0]  read_addr,
	output logic                         read_valid
);
	import dale_pkg::*;

	// count width, wide enough to hold DEPTH itself
	localparam int CNT_W = $clog2(DEPTH + 1);

	// common width for comparing read_index against the count
	localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	// state
	logic [CNT_W-1:0]   count_q;
	logic               out_valid_q;
	logic               found_q;
	logic [CNT_W-1:0]   count_out_q;
	logic [ADDR_W-1:0]  raddr_q;
	logic               rvalid_q;

	// cell row
	logic [ADDR_W-1:0]  cell_data [DEPTH];
	logic [DEPTH-1:0]   cell_match;
	logic [DEPTH-1:0]   cell_live;
	cell_ctl_t          cell_ctl [DEPTH];

	// request decode
	logic               in_acc;
	logic               hit;
	logic               full;
	logic               do_add;
	logic               found_d;
	logic [CNT_W-1:0]   count_d;
	logic [ADDR_W-1:0]  raddr_d;
	logic               rvalid_d;

	// the only backpressure: a held result blocks new requests
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	assign hit  = |cell_match;
	assign full = (count_q == CNT_W'(DEPTH));

	// add of a new address: append, or shift the row when full
	assign do_add = in_acc && (op == OP_ADD) && !hit;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			localparam logic [CNT_W-1:0] SLOT = CNT_W'(gi);
			logic [ADDR_W-1:0] nbr;

			if (gi == DEPTH - 1) begin : g_top
				assign nbr = ip_addr;
			end else begin : g_mid
				assign nbr = cell_data[gi + 1];
			end

			assign cell_live[gi]      = (SLOT < count_q);
			assign cell_ctl[gi].shift = do_add && full;
			assign cell_ctl[gi].load  = do_add && !full && (count_q == SLOT);

			dale_cell u_cell (
				.clk      (clk),
				.ctl      (cell_ctl[gi]),
				.live     (cell_live[gi]),
				.nbr_data (nbr),
				.new_data (ip_addr),
				.key      (ip_addr),
				.data     (cell_data[gi]),
				.match    (cell_match[gi])
			);
		end
	endgenerate

	// result fields
	always_comb begin
		found_d  = 1'b0;
		rvalid_d = 1'b0;
		unique case (op)
			OP_ADD, OP_LOOKUP: begin
				found_d = hit;
			end
			OP_READ: begin
				rvalid_d = (CMP_W'(read_index) < CMP_W'(count_q));
			end
			default: begin
			end
		endcase
	end

	// read select: one-hot OR over the row
	always_comb begin
		raddr_d = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (rvalid_d && (CMP_W'(read_index) == CMP_W'(i))) begin
				raddr_d = raddr_d | cell_data[i];
			end
		end
	end

	assign count_d = count_q + CNT_W'(do_add && !full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				count_q <= count_d;
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			found_q     <= found_d;
			count_out_q <= count_d;
			raddr_q     <= raddr_d;
			rvalid_q    <= rvalid_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign entry_count = count_out_q;
	assign read_addr   = raddr_q;
	assign read_valid  = rvalid_q;

	// count never passes the list size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above DEPTH");

	// a lookup or read leaves the count alone
	a_lookup_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (op == OP_LOOKUP || op == OP_READ) |=> count_q == $past(count_q))
		else $error("count moved on lookup or read");

	// found and read_valid come from different ops
	a_found_vs_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(found_q && rvalid_q))
		else $error("found and read_valid both set");

	// a duplicate add never grows the list
	a_dup_add: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (op == OP_ADD) && hit |=> count_q == $past(count_q))
		else $error("duplicate add changed count");

endmodule
